FILE: hdl/tps_pkg.sv
package tps_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned RELOAD_W = 8;
  localparam int unsigned DIST_W   = 24;

  // Timer clock, request ceiling and the starting distance of the search.
  localparam int unsigned CLOCK_HZ       = 2457600;
  localparam int unsigned REQUEST_LIMIT  = 614400;
  localparam int unsigned START_DISTANCE = 24'hFFFFFF;
  localparam int unsigned RELOAD_MAX     = 255;

  // Prescaler indexes run 0..6; the timer code is the index plus one.
  localparam int unsigned NUM_PRESC = 7;
  localparam logic [CODE_W-1:0] PRESC_FIRST = CODE_W'(NUM_PRESC - 1);
  localparam logic [CODE_W-1:0] PRESC_LAST  = '0;

  // Prescaled clock rates for each divider.
  localparam int unsigned BASE_DIV4   = CLOCK_HZ / 4;
  localparam int unsigned BASE_DIV10  = CLOCK_HZ / 10;
  localparam int unsigned BASE_DIV16  = CLOCK_HZ / 16;
  localparam int unsigned BASE_DIV50  = CLOCK_HZ / 50;
  localparam int unsigned BASE_DIV64  = CLOCK_HZ / 64;
  localparam int unsigned BASE_DIV100 = CLOCK_HZ / 100;
  localparam int unsigned BASE_DIV200 = CLOCK_HZ / 200;

  // Divider: quotient bits produced per cycle.
  localparam int unsigned DIV_BITS_PER_STEP = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic eval;
    logic next_reload;
    logic next_presc;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic below;
    logic last_reload;
    logic last_presc;
  } status_t;

  // Prescaled clock rate for a prescaler index.
  function automatic logic [RATE_W-1:0] base_rate(input logic [CODE_W-1:0] idx);
    logic [RATE_W-1:0] rate;
    case (idx)
      3'd0:    rate = RATE_W'(BASE_DIV4);
      3'd1:    rate = RATE_W'(BASE_DIV10);
      3'd2:    rate = RATE_W'(BASE_DIV16);
      3'd3:    rate = RATE_W'(BASE_DIV50);
      3'd4:    rate = RATE_W'(BASE_DIV64);
      3'd5:    rate = RATE_W'(BASE_DIV100);
      3'd6:    rate = RATE_W'(BASE_DIV200);
      default: rate = RATE_W'(BASE_DIV200);
    endcase
    return rate;
  endfunction

endpackage

FILE: hdl/tps_div.sv
module tps_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tps_pkg::RATE_W-1:0]     dividend,
  input  logic [tps_pkg::RELOAD_W-1:0]   divisor,
  output logic                           done,
  output logic [tps_pkg::RATE_W-1:0]     quotient
);

  localparam int unsigned QW    = tps_pkg::RATE_W;
  localparam int unsigned DW    = tps_pkg::RELOAD_W;
  localparam int unsigned BPS   = tps_pkg::DIV_BITS_PER_STEP;
  localparam int unsigned STEPS = (QW + BPS - 1) / BPS;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [QW-1:0]    num_r, num_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [DW:0] trial;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int i = 0; i < BPS; i++) begin
      trial   = {rem_nxt, num_nxt[QW-1]};
      num_nxt = {num_nxt[QW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DW'(trial - {1'b0, divisor});
        quo_nxt = {quo_nxt[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      end
    end
  end

  // Control: run flag, step count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath registers. The dividend is left-aligned so that the last
  // step ends on its lowest bit.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend << (STEPS * BPS - QW);
      quo_r <= '0;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/tps_dp.sv
module tps_dp #(
  parameter int unsigned RELOAD_MAX = tps_pkg::RELOAD_MAX
) (
  input  logic                           clk,
  input  tps_pkg::cmd_t                  cmd,
  output tps_pkg::status_t               status,
  input  logic [tps_pkg::RATE_W-1:0]     request_hz,
  output logic [tps_pkg::CODE_W-1:0]     prescale_code,
  output logic [tps_pkg::RELOAD_W-1:0]   reload_value,
  output logic [tps_pkg::RATE_W-1:0]     achieved_hz
);

  localparam int unsigned RW = tps_pkg::RATE_W;
  localparam int unsigned CW = tps_pkg::CODE_W;
  localparam int unsigned LW = tps_pkg::RELOAD_W;
  localparam int unsigned DW = tps_pkg::DIST_W;

  logic [RW-1:0] req_r;
  logic [CW-1:0] presc_r;
  logic [LW-1:0] reload_r;
  logic [DW-1:0] best_dist_r;
  logic [CW-1:0] best_code_r;
  logic [LW-1:0] best_reload_r;
  logic [RW-1:0] best_rate_r;

  logic          div_done;
  logic [RW-1:0] rate;
  logic [RW-1:0] cand_dist;
  logic          better;

  tps_div u_div (
    .clk      (clk),
    .rst_n    (1'b1),
    .start    (cmd.div_start),
    .dividend (tps_pkg::base_rate(presc_r)),
    .divisor  (reload_r),
    .done     (div_done),
    .quotient (rate)
  );

  // Distance of the candidate rate to the request.
  always_comb begin
    cand_dist = (req_r > rate) ? (req_r - rate) : (rate - req_r);
    better    = ({{(DW - RW){1'b0}}, cand_dist} < best_dist_r);
  end

  // Search position and saturated request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= (request_hz > RW'(tps_pkg::REQUEST_LIMIT)) ?
                  RW'(tps_pkg::REQUEST_LIMIT) : request_hz;
      presc_r  <= tps_pkg::PRESC_FIRST;
      reload_r <= LW'(1);
    end else if (cmd.next_presc) begin
      presc_r  <= presc_r - 1'b1;
      reload_r <= LW'(1);
    end else if (cmd.next_reload) begin
      reload_r <= reload_r + 1'b1;
    end
  end

  // Best candidate so far.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_dist_r   <= DW'(tps_pkg::START_DISTANCE);
      best_code_r   <= CW'(1);
      best_reload_r <= LW'(1);
      best_rate_r   <= '0;
    end else if (cmd.eval && better) begin
      best_dist_r   <= {{(DW - RW){1'b0}}, cand_dist};
      best_code_r   <= presc_r + 1'b1;
      best_reload_r <= reload_r;
      best_rate_r   <= rate;
    end
  end

  always_comb begin
    status.div_done    = div_done;
    status.below       = (rate < req_r);
    status.last_reload = (reload_r == LW'(RELOAD_MAX));
    status.last_presc  = (presc_r == tps_pkg::PRESC_LAST);
  end

  assign prescale_code = best_code_r;
  assign reload_value  = best_reload_r;
  assign achieved_hz   = best_rate_r;

endmodule

FILE: hdl/tps_ctrl.sv
module tps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tps_pkg::cmd_t     cmd,
  input  tps_pkg::status_t  status
);

  tps_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      tps_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = tps_pkg::ST_START;
        end
      end
      tps_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = tps_pkg::ST_DIV;
      end
      tps_pkg::ST_DIV: begin
        if (status.div_done) begin
          cmd.eval = 1'b1;
          if (status.below || status.last_reload) begin
            if (status.last_presc) begin
              state_nxt = tps_pkg::ST_DONE;
            end else begin
              cmd.next_presc = 1'b1;
              state_nxt      = tps_pkg::ST_START;
            end
          end else begin
            cmd.next_reload = 1'b1;
            state_nxt       = tps_pkg::ST_START;
          end
        end
      end
      // The result cycle also takes the next request.
      tps_pkg::ST_DONE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = tps_pkg::ST_START;
        end else begin
          state_nxt = tps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tps_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != tps_pkg::ST_IDLE);
  assign out_valid = (state_r == tps_pkg::ST_DONE);

endmodule

FILE: hdl/timer_prescaler_search_top.sv
// Timer prescaler and reload search. Pulse start while busy is low to
// submit a requested rate; requests above 614400 Hz are clamped. The block
// walks the prescalers from divide-by-200 down to divide-by-4 and, for
// each, reload values from 1 upward until the rate drops below the request
// or the reload limit is reached. Each candidate takes a launch step, a
// run of the shared divider that yields 4 quotient bits per cycle, and a
// compare step; a request of zero tries all 1785 candidates. The
// result appears for exactly one cycle with out_valid high, and busy falls
// in that same cycle; the receiver cannot stall it, so it must capture the
// result when out_valid is seen.
module timer_prescaler_search_top #(
  parameter int unsigned RELOAD_MAX = tps_pkg::RELOAD_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tps_pkg::RATE_W-1:0]     in_request_hz,
  output logic                           out_valid,
  output logic [tps_pkg::CODE_W-1:0]     out_prescale_code,
  output logic [tps_pkg::RELOAD_W-1:0]   out_reload_value,
  output logic [tps_pkg::RATE_W-1:0]     out_achieved_hz
);

  tps_pkg::cmd_t    cmd;
  tps_pkg::status_t status;
  logic             ctrl_busy;
  logic             done_pulse;

  tps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (ctrl_busy),
    .out_valid (done_pulse),
    .cmd       (cmd),
    .status    (status)
  );

  tps_dp #(
    .RELOAD_MAX (RELOAD_MAX)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .request_hz    (in_request_hz),
    .prescale_code (out_prescale_code),
    .reload_value  (out_reload_value),
    .achieved_hz   (out_achieved_hz)
  );

  // The result cycle also frees the block for the next request.
  assign busy      = ctrl_busy && !done_pulse;
  assign out_valid = done_pulse;

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import tps_pkg::*;

  // Stop after this many cycles without an accepted request or result.
  // The limit is well above the longest search, that of a zero request.
  localparam int unsigned STALL_LIMIT  = 60000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned RANDOM_ITEMS = 115;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [RELOAD_W-1:0] reload;
    logic [RATE_W-1:0]   rate;
  } timer_setting_t;

  // Holds predicted timer settings in request order and checks results.
  class timer_scoreboard;
    timer_setting_t pending_q[$];
    int unsigned    errors;

    function new();
      errors = 0;
    endfunction

    static function int unsigned divider_of(int idx);
      int unsigned divider;
      case (idx)
        0: divider = 4;
        1: divider = 10;
        2: divider = 16;
        3: divider = 50;
        4: divider = 64;
        5: divider = 100;
        default: divider = 200;
      endcase
      return divider;
    endfunction

    // Search prescalers from the largest divider down and reloads upward,
    // keeping the first candidate that comes strictly closest.
    static function timer_setting_t predict_setting(logic [RATE_W-1:0] raw_req);
      logic [RATE_W-1:0] req;
      logic [RATE_W-1:0] rate;
      logic [DIST_W-1:0] cand_dist;
      logic [DIST_W-1:0] best_dist;
      int unsigned       base;
      timer_setting_t    best;
      req = (raw_req > REQUEST_LIMIT) ? RATE_W'(REQUEST_LIMIT) : raw_req;
      best_dist = DIST_W'(START_DISTANCE);
      best.code = CODE_W'(1);
      best.reload = RELOAD_W'(1);
      best.rate = '0;
      for (int p = NUM_PRESC - 1; p >= 0; p--) begin
        base = CLOCK_HZ / divider_of(p);
        for (int unsigned r = 1; r <= RELOAD_MAX; r++) begin
          rate = RATE_W'(base / r);
          cand_dist = (req > rate) ? DIST_W'(req - rate) : DIST_W'(rate - req);
          if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            best.code = CODE_W'(p + 1);
            best.reload = RELOAD_W'(r);
            best.rate = rate;
          end
          if (rate < req) break;
        end
      end
      return best;
    endfunction

    function void note_request(logic [RATE_W-1:0] req);
      pending_q.push_back(predict_setting(req));
    endfunction

    function void check_result(timer_setting_t got);
      timer_setting_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result code %0d reload %0d rate %0d",
                 $time, got.code, got.reload, got.rate);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.code != want.code) begin
        $display("%0t: prescale_code expected %0d actual %0d", $time, want.code, got.code);
        errors++;
      end
      if (got.reload != want.reload) begin
        $display("%0t: reload_value expected %0d actual %0d",
                 $time, want.reload, got.reload);
        errors++;
      end
      if (got.rate != want.rate) begin
        $display("%0t: achieved_hz expected %0d actual %0d", $time, want.rate, got.rate);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending_q.size() != 0) begin
        $display("%0t: %0d results never arrived, next expected code %0d reload %0d rate %0d",
                 $time, pending_q.size(), pending_q[0].code, pending_q[0].reload,
                 pending_q[0].rate);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [RATE_W-1:0]   in_request_hz;
  logic                out_valid;
  logic [CODE_W-1:0]   out_prescale_code;
  logic [RELOAD_W-1:0] out_reload_value;
  logic [RATE_W-1:0]   out_achieved_hz;

  timer_scoreboard board;
  int unsigned     idle_pct;
  int unsigned     stall_count;

  // Extremes, saturation, exact candidate rates and midpoint ties.
  logic [RATE_W-1:0] directed_q[$] = '{
    20'd0, 20'd1, 20'd2, 20'd614400, 20'd614399, 20'd614401, 20'hFFFFF,
    20'h80000, 20'h7FFFF, 20'h55555, 20'hAAAAA, 20'd12288, 20'd6144, 20'd9216,
    20'd24576, 20'd49152, 20'd153600, 20'd245760, 20'd307200, 20'd460800,
    20'd50, 20'd100, 20'd1000, 20'd48, 20'd2409
  };

  timer_prescaler_search_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_request_hz     (in_request_hz),
    .out_valid         (out_valid),
    .out_prescale_code (out_prescale_code),
    .out_reload_value  (out_reload_value),
    .out_achieved_hz   (out_achieved_hz)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one request at a falling edge, after a random number of idle
  // cycles, and hold it until the block takes it.
  task automatic send_request(input logic [RATE_W-1:0] req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_request_hz <= req;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random requests, weighted toward the short searches of large rates,
  // with a share near exact candidate rates and a few full-length searches.
  function automatic logic [RATE_W-1:0] random_request();
    int unsigned sel;
    int unsigned rate;
    sel = $urandom_range(99);
    if (sel < 35) return RATE_W'($urandom_range(20'hFFFFF));
    if (sel < 55) return RATE_W'($urandom_range(REQUEST_LIMIT));
    if (sel < 72) begin
      rate = (CLOCK_HZ / timer_scoreboard::divider_of($urandom_range(NUM_PRESC - 1)))
             / $urandom_range(1, 20);
      return RATE_W'(rate + $urandom_range(4) - 2);
    end
    if (sel < 87) return RATE_W'($urandom_range(100000, 2000));
    if (sel < 97) return RATE_W'($urandom_range(3000, 49));
    return RATE_W'($urandom_range(48));
  endfunction

  // Note accepted requests, check results and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_request(in_request_hz);
      end
      if (out_valid) begin
        board.check_result({out_prescale_code, out_reload_value, out_achieved_hz});
      end
      if ((start && !busy) || out_valid) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_count);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_request_hz = '0;
    stall_count = 0;
    idle_pct = 11;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_q[i]) begin
      send_request(directed_q[i]);
    end

    // Sender idles lightly, then heavily, then never.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) idle_pct = 83;
      if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      send_request(random_request());
    end
    start <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
